FILE: sv/awil_pkg.sv
// shared types, constants and the control-store program for the angle-wrap iir rate core
// no dependencies; imported by the sequencer, the datapath and the top level
package awil_pkg;

  // default widths and fixed-point layout
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF   = 32;
  localparam int RATE_WIDTH       = 32;
  localparam int FRAC_COEF        = 28;
  localparam int FRAC_SAMPLE      = 16;
  localparam int HALF_TURN        = 180;
  localparam int FULL_TURN        = 360;
  localparam int CFG_IDX_W        = 4;

  // register reset values, sign-extended to 64 bits
  localparam logic signed [63:0] RST_B_OUTER   = 64'sd3569;
  localparam logic signed [63:0] RST_B_INNER   = 64'sd14274;
  localparam logic signed [63:0] RST_B_CENTER  = 64'sd21411;
  localparam logic signed [63:0] RST_A_ONE     = -64'sd985622276;
  localparam logic signed [63:0] RST_A_TWO     = 64'sd1360430458;
  localparam logic signed [63:0] RST_A_THREE   = -64'sd836436002;
  localparam logic signed [63:0] RST_A_FOUR    = 64'sd193249456;
  localparam logic signed [63:0] RST_OUT_SCALE = 64'sd268435456;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B_OUTER   = 4'd0,
    REG_B_INNER   = 4'd1,
    REG_B_CENTER  = 4'd2,
    REG_A_ONE     = 4'd3,
    REG_A_TWO     = 4'd4,
    REG_A_THREE   = 4'd5,
    REG_A_FOUR    = 4'd6,
    REG_OUT_SCALE = 4'd7
  } reg_idx_t;

  // program counter
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] LAST_STEP = 4'd14;

  // control word fields
  typedef enum logic [2:0] {
    C_B_OUTER, C_B_INNER, C_B_CENTER, C_A_ONE, C_A_TWO, C_A_THREE, C_A_FOUR, C_SCALE
  } coef_sel_t;

  typedef enum logic [3:0] {
    O_X_NEW, O_XH0, O_XH1, O_XH2, O_XH3, O_YH0, O_YH1, O_YH2, O_YH3, O_SREG
  } opnd_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    RND_NONE, RND_ACC, RND_PROD
  } rnd_sel_t;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_WAIT_IN, SEQ_WAIT_OUT
  } seq_op_t;

  typedef struct packed {
    coef_sel_t csel;
    opnd_sel_t osel;
    acc_op_t   acc;
    rnd_sel_t  rnd;
    logic      commit;
    seq_op_t   seq;
  } ctrl_t;

  function automatic ctrl_t mk(input coef_sel_t c, input opnd_sel_t o, input acc_op_t a,
                               input rnd_sel_t r, input logic cm, input seq_op_t s);
    ctrl_t w;
    w.csel   = c;
    w.osel   = o;
    w.acc    = a;
    w.rnd    = r;
    w.commit = cm;
    w.seq    = s;
    return w;
  endfunction

  // control store: multiplies are registered, so each accumulating step takes the product of the step before
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      4'd0:    w = mk(C_B_OUTER,  O_X_NEW, ACC_NONE, RND_NONE, 1'b0, SEQ_WAIT_IN);
      4'd1:    w = mk(C_B_OUTER,  O_X_NEW, ACC_NONE, RND_NONE, 1'b0, SEQ_NEXT);
      4'd2:    w = mk(C_B_INNER,  O_XH0,   ACC_LOAD, RND_NONE, 1'b0, SEQ_NEXT);
      4'd3:    w = mk(C_B_CENTER, O_XH1,   ACC_ADD,  RND_NONE, 1'b0, SEQ_NEXT);
      4'd4:    w = mk(C_B_INNER,  O_XH2,   ACC_ADD,  RND_NONE, 1'b0, SEQ_NEXT);
      4'd5:    w = mk(C_B_OUTER,  O_XH3,   ACC_ADD,  RND_NONE, 1'b0, SEQ_NEXT);
      4'd6:    w = mk(C_A_ONE,    O_YH0,   ACC_ADD,  RND_NONE, 1'b0, SEQ_NEXT);
      4'd7:    w = mk(C_A_TWO,    O_YH1,   ACC_SUB,  RND_NONE, 1'b0, SEQ_NEXT);
      4'd8:    w = mk(C_A_THREE,  O_YH2,   ACC_SUB,  RND_NONE, 1'b0, SEQ_NEXT);
      4'd9:    w = mk(C_A_FOUR,   O_YH3,   ACC_SUB,  RND_NONE, 1'b0, SEQ_NEXT);
      4'd10:   w = mk(C_SCALE,    O_SREG,  ACC_SUB,  RND_NONE, 1'b0, SEQ_NEXT);
      4'd11:   w = mk(C_SCALE,    O_SREG,  ACC_NONE, RND_ACC,  1'b0, SEQ_NEXT);
      4'd12:   w = mk(C_SCALE,    O_SREG,  ACC_NONE, RND_NONE, 1'b0, SEQ_NEXT);
      4'd13:   w = mk(C_SCALE,    O_SREG,  ACC_NONE, RND_PROD, 1'b0, SEQ_NEXT);
      4'd14:   w = mk(C_SCALE,    O_SREG,  ACC_NONE, RND_NONE, 1'b1, SEQ_WAIT_OUT);
      default: w = mk(C_B_OUTER,  O_X_NEW, ACC_NONE, RND_NONE, 1'b0, SEQ_WAIT_OUT);
    endcase
    return w;
  endfunction

endpackage

FILE: sv/awil_seq.sv
// microcode sequencer: step counter and control-store lookup with wait conditions
// depends on awil_pkg for the control word and the program
module awil_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_busy,
  output logic           in_stall,
  output logic           in_accept,
  output awil_pkg::ctrl_t ctrl
);
  import awil_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;

  // current control word
  assign ctrl      = ucode(pc_r);
  assign in_stall  = (ctrl.seq != SEQ_WAIT_IN);
  assign in_accept = in_valid && !in_stall;

  // next step with conditional holds
  always_comb begin
    case (ctrl.seq)
      SEQ_NEXT:     pc_nxt = pc_r + 4'd1;
      SEQ_WAIT_IN:  pc_nxt = in_valid ? pc_r + 4'd1 : pc_r;
      SEQ_WAIT_OUT: pc_nxt = out_busy ? pc_r : '0;
      default:      pc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // program counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n) pc_r <= LAST_STEP)
    else $error("step counter beyond program end");

  // idle step holds until an item arrives
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == '0 && !in_valid) |=> pc_r == '0)
    else $error("sequencer left idle without an item");

  // last step returns to idle once the output register is free
  a_wrap_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == LAST_STEP && !out_busy) |=> pc_r == '0)
    else $error("sequencer did not return to idle");

  // middle steps advance one a cycle
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != '0 && pc_r != LAST_STEP) |=> pc_r == $past(pc_r) + 4'd1)
    else $error("sequencer skipped or held a step");

endmodule

FILE: sv/awil_dp.sv
// datapath: coefficient registers, wrap unit, history, shared mac, rounding and output register
// depends on awil_pkg for the control word, register indexes and constants
module awil_dp #(
  parameter int SAMPLE_WIDTH = awil_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = awil_pkg::COEF_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  awil_pkg::ctrl_t                       ctrl,
  input  logic                                  in_accept,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_angle_sample,
  input  logic                                  cfg_we,
  input  logic [awil_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [COEF_WIDTH-1:0]                 cfg_data,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic signed [awil_pkg::RATE_WIDTH-1:0] out_angle_rate,
  output logic                                  out_busy
);
  import awil_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COEF_WIDTH;
  localparam int PW = SW + CW;
  localparam int AW = PW + 4;
  localparam int DW = ((SW > 26) ? SW : 26) + 1;
  localparam int RW = ((SW + 1 > RATE_WIDTH + 1) ? SW + 1 : RATE_WIDTH + 1);

  localparam logic signed [AW:0] RND_HALF =
    {{(AW + 1 - FRAC_COEF){1'b0}}, 1'b1, {(FRAC_COEF - 1){1'b0}}};
  localparam logic signed [AW:0] A_SMAX = {{(AW + 2 - SW){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [AW:0] A_SMIN = ~A_SMAX;
  localparam logic signed [DW-1:0] D_SMAX = {{(DW + 1 - SW){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [DW-1:0] D_SMIN = ~D_SMAX;
  localparam logic signed [DW-1:0] HALF_Q = DW'(HALF_TURN * (1 << FRAC_SAMPLE));
  localparam logic signed [DW-1:0] FULL_Q = DW'(FULL_TURN * (1 << FRAC_SAMPLE));
  localparam logic signed [RW-1:0] R_MAX = {{(RW + 1 - RATE_WIDTH){1'b0}},
                                            {(RATE_WIDTH - 1){1'b1}}};
  localparam logic signed [RW-1:0] R_MIN = ~R_MAX;

  // round half up by the coefficient fraction, then saturate to sample width
  function automatic logic signed [SW-1:0] rnd_sat(input logic signed [AW-1:0] v);
    logic signed [AW:0] t;
    logic signed [AW:0] s;
    t = {v[AW-1], v} + RND_HALF;
    s = t >>> FRAC_COEF;
    if (s > A_SMAX) return A_SMAX[SW-1:0];
    else if (s < A_SMIN) return A_SMIN[SW-1:0];
    else return s[SW-1:0];
  endfunction

  // history entry plus wrap offset, saturated
  function automatic logic signed [SW-1:0] wrap_sat(input logic signed [SW-1:0] h,
                                                    input logic signed [DW-1:0] adj);
    logic signed [DW-1:0] t;
    t = {{(DW - SW){h[SW-1]}}, h} + adj;
    if (t > D_SMAX) return D_SMAX[SW-1:0];
    else if (t < D_SMIN) return D_SMIN[SW-1:0];
    else return t[SW-1:0];
  endfunction

  logic signed [CW-1:0] b_outer_r, b_inner_r, b_center_r;
  logic signed [CW-1:0] a_one_r, a_two_r, a_three_r, a_four_r, out_scale_r;
  logic signed [SW-1:0] xh_r [4];
  logic signed [SW-1:0] yh_r [4];
  logic signed [SW-1:0] x_r;
  logic signed [SW-1:0] sreg_r;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic                 out_valid_r;
  logic signed [RATE_WIDTH-1:0] out_rate_r;

  logic signed [CW-1:0] mc;
  logic signed [SW-1:0] mx;
  logic signed [PW-1:0] prod_nxt;
  logic signed [AW-1:0] prod_ext;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] adj;
  logic signed [RW-1:0] rate_full;
  logic signed [RATE_WIDTH-1:0] rate_nxt;
  logic                 fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_outer_r   <= RST_B_OUTER[CW-1:0];
      b_inner_r   <= RST_B_INNER[CW-1:0];
      b_center_r  <= RST_B_CENTER[CW-1:0];
      a_one_r     <= RST_A_ONE[CW-1:0];
      a_two_r     <= RST_A_TWO[CW-1:0];
      a_three_r   <= RST_A_THREE[CW-1:0];
      a_four_r    <= RST_A_FOUR[CW-1:0];
      out_scale_r <= RST_OUT_SCALE[CW-1:0];
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B_OUTER:   b_outer_r   <= cfg_data;
        REG_B_INNER:   b_inner_r   <= cfg_data;
        REG_B_CENTER:  b_center_r  <= cfg_data;
        REG_A_ONE:     a_one_r     <= cfg_data;
        REG_A_TWO:     a_two_r     <= cfg_data;
        REG_A_THREE:   a_three_r   <= cfg_data;
        REG_A_FOUR:    a_four_r    <= cfg_data;
        REG_OUT_SCALE: out_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // wrap decision against the incoming sample
  always_comb begin
    diff = {{(DW - SW){yh_r[0][SW-1]}}, yh_r[0]}
         - {{(DW - SW){in_angle_sample[SW-1]}}, in_angle_sample};
    if (diff > HALF_Q) adj = -FULL_Q;
    else if (diff < -HALF_Q) adj = FULL_Q;
    else adj = '0;
  end

  // multiplier operand selection
  always_comb begin
    case (ctrl.csel)
      C_B_OUTER:  mc = b_outer_r;
      C_B_INNER:  mc = b_inner_r;
      C_B_CENTER: mc = b_center_r;
      C_A_ONE:    mc = a_one_r;
      C_A_TWO:    mc = a_two_r;
      C_A_THREE:  mc = a_three_r;
      C_A_FOUR:   mc = a_four_r;
      C_SCALE:    mc = out_scale_r;
      default:    mc = out_scale_r;
    endcase
    case (ctrl.osel)
      O_X_NEW: mx = x_r;
      O_XH0:   mx = xh_r[0];
      O_XH1:   mx = xh_r[1];
      O_XH2:   mx = xh_r[2];
      O_XH3:   mx = xh_r[3];
      O_YH0:   mx = yh_r[0];
      O_YH1:   mx = yh_r[1];
      O_YH2:   mx = yh_r[2];
      O_YH3:   mx = yh_r[3];
      O_SREG:  mx = sreg_r;
      default: mx = sreg_r;
    endcase
  end

  assign prod_nxt = mc * mx;
  assign prod_ext = {{(AW - PW){prod_r[PW-1]}}, prod_r};

  // rate from new and previous output, saturated
  always_comb begin
    rate_full = {{(RW - SW){sreg_r[SW-1]}}, sreg_r} - {{(RW - SW){yh_r[0][SW-1]}}, yh_r[0]};
    if (rate_full > R_MAX) rate_nxt = R_MAX[RATE_WIDTH-1:0];
    else if (rate_full < R_MIN) rate_nxt = R_MIN[RATE_WIDTH-1:0];
    else rate_nxt = rate_full[RATE_WIDTH-1:0];
  end

  assign out_busy = out_valid_r && out_stall;
  assign fire     = ctrl.commit && !out_busy;

  // mac pipeline and rounding register
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (ctrl.acc)
      ACC_LOAD: acc_r <= prod_ext;
      ACC_ADD:  acc_r <= acc_r + prod_ext;
      ACC_SUB:  acc_r <= acc_r - prod_ext;
      default:  acc_r <= acc_r;
    endcase
    case (ctrl.rnd)
      RND_ACC:  sreg_r <= rnd_sat(acc_r);
      RND_PROD: sreg_r <= rnd_sat(prod_ext);
      default:  sreg_r <= sreg_r;
    endcase
    if (in_accept) begin
      x_r <= in_angle_sample;
    end
  end

  // history: wrapped on accept, shifted on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        xh_r[k] <= '0;
        yh_r[k] <= '0;
      end
    end else if (in_accept) begin
      for (int k = 0; k < 4; k++) begin
        xh_r[k] <= wrap_sat(xh_r[k], adj);
        yh_r[k] <= wrap_sat(yh_r[k], adj);
      end
    end else if (fire) begin
      for (int k = 3; k > 0; k--) begin
        xh_r[k] <= xh_r[k-1];
        yh_r[k] <= yh_r[k-1];
      end
      xh_r[0] <= x_r;
      yh_r[0] <= sreg_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      out_rate_r <= rate_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_angle_rate = out_rate_r;

endmodule

FILE: sv/angle_wrap_iir_lowpass_rate_core.sv
// Angle-wrapping fourth-order IIR low-pass that reports angular rate.
// Each item takes nine products and one scaling multiply through the single
// shared multiplier of the microcoded datapath; a new item waits until the last is through.
// An unread result stretches the last step until the output register frees.
// Reset (synchronous, active low) clears history, restores default coefficients.
module angle_wrap_iir_lowpass_rate_core #(
  parameter int SAMPLE_WIDTH = awil_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = awil_pkg::COEF_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_angle_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [awil_pkg::RATE_WIDTH-1:0] out_angle_rate,
  input  logic                                   cfg_we,
  input  logic [awil_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [COEF_WIDTH-1:0]                  cfg_data
);
  import awil_pkg::*;

  ctrl_t ctrl;
  logic  in_accept;
  logic  out_busy;

  // step counter and control store
  awil_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_busy  (out_busy),
    .in_stall  (in_stall),
    .in_accept (in_accept),
    .ctrl      (ctrl)
  );

  // arithmetic, history and output register
  awil_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .in_accept       (in_accept),
    .in_angle_sample (in_angle_sample),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_angle_rate  (out_angle_rate),
    .out_busy        (out_busy)
  );

endmodule
